FILE: rtl/fdhc_pkg.sv
// ----------------------------------------------------------------------------
// fdhc_pkg
// Types and constants shared by the frame deframer and hash checker.
// ----------------------------------------------------------------------------
package fdhc_pkg;

	localparam int unsigned HDR_LEN   = 20;
	localparam int unsigned SUM_LEN   = 4;
	localparam int unsigned QDEPTH    = 4;
	localparam int unsigned QPTR_W    = $clog2(QDEPTH);
	localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

	localparam logic [1:0] KIND_USER    = 2'd0;
	localparam logic [1:0] KIND_BODY    = 2'd1;
	localparam logic [1:0] KIND_SUMMARY = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_SHORT     = 2'd1;
	localparam logic [1:0] ST_TRUNC     = 2'd2;
	localparam logic [1:0] ST_MISMATCH  = 2'd3;

	typedef struct packed {
		logic [1:0]  item_kind;
		logic [7:0]  payload_byte;
		logic [1:0]  frame_status;
		logic [15:0] version_field;
		logic [15:0] command_field;
		logic [63:0] request_ident;
		logic [31:0] user_length;
		logic [31:0] body_length;
		logic [31:0] stored_sum;
		logic [31:0] computed_sum;
		logic        last_of_run;
	} res_t;

	typedef struct packed {
		logic push_pay;
		logic push_sum;
	} push_t;

	typedef struct packed {
		logic [QCNT_W-1:0] level;
		logic              room;
	} qstat_t;

endpackage

FILE: rtl/fdhc_core.sv
// ----------------------------------------------------------------------------
// fdhc_core
// Frame state, header capture, running hash and result formation per word.
// ----------------------------------------------------------------------------
module fdhc_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [7:0]         data_byte,
	input  logic               end_of_frame,
	output fdhc_pkg::push_t    push,
	output fdhc_pkg::res_t     pay_res,
	output fdhc_pkg::res_t     sum_res
);
	import fdhc_pkg::*;

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_USER   = 3'd1;
	localparam logic [2:0] PH_BODY   = 3'd2;
	localparam logic [2:0] PH_SUM    = 3'd3;
	localparam logic [2:0] PH_DONE   = 3'd4;

	logic [2:0]   phase_q, phase_n;
	logic [4:0]   hcnt_q, hcnt_n;
	logic [159:0] hdr_q, hdr_n;
	logic [31:0]  rem_q, rem_n;
	logic [31:0]  hash_q, hash_n;
	logic [31:0]  sum_q, sum_n;
	logic [1:0]   scnt_q, scnt_n;
	logic         is_pay;
	logic [1:0]   status;

	always_comb begin
		phase_n = phase_q;
		hcnt_n  = hcnt_q;
		hdr_n   = hdr_q;
		rem_n   = rem_q;
		hash_n  = hash_q;
		sum_n   = sum_q;
		scnt_n  = scnt_q;
		is_pay  = 1'b0;
		unique case (phase_q)
			PH_HEADER: begin
				if (hcnt_q < 5'(HDR_LEN)) begin
					hdr_n[{hcnt_q, 3'b000} +: 8] = data_byte;
				end
				hcnt_n = hcnt_q + 5'd1;
				if (hcnt_n == 5'(HDR_LEN)) begin
					if (hdr_n[127:96] != 32'd0) begin
						phase_n = PH_USER;
						rem_n   = hdr_n[127:96];
					end else if (hdr_n[159:128] != 32'd0) begin
						phase_n = PH_BODY;
						rem_n   = hdr_n[159:128];
					end else begin
						phase_n = PH_SUM;
					end
				end
			end
			PH_USER, PH_BODY: begin
				is_pay = 1'b1;
				hash_n = (hash_q << 7) + (hash_q << 1) + hash_q + {24'd0, data_byte};
				rem_n  = rem_q - 32'd1;
				if (rem_n == 32'd0) begin
					if (phase_q == PH_USER && hdr_q[159:128] != 32'd0) begin
						phase_n = PH_BODY;
						rem_n   = hdr_q[159:128];
					end else begin
						phase_n = PH_SUM;
					end
				end
			end
			PH_SUM: begin
				sum_n[{scnt_q, 3'b000} +: 8] = data_byte;
				scnt_n = scnt_q + 2'd1;
				if (scnt_q == 2'(SUM_LEN - 1)) begin
					phase_n = PH_DONE;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		priority if (phase_n == PH_HEADER) begin
			status = ST_SHORT;
		end else if (phase_n == PH_DONE) begin
			status = (sum_n == hash_n) ? ST_OK : ST_MISMATCH;
		end else begin
			status = ST_TRUNC;
		end
	end

	always_comb begin
		pay_res              = '0;
		pay_res.item_kind    = (phase_q == PH_USER) ? KIND_USER : KIND_BODY;
		pay_res.payload_byte = data_byte;
		pay_res.last_of_run  = ~end_of_frame;

		sum_res               = '0;
		sum_res.item_kind     = KIND_SUMMARY;
		sum_res.frame_status  = status;
		sum_res.version_field = hdr_n[15:0];
		sum_res.command_field = hdr_n[31:16];
		sum_res.request_ident = hdr_n[95:32];
		sum_res.user_length   = hdr_n[127:96];
		sum_res.body_length   = hdr_n[159:128];
		sum_res.stored_sum    = sum_n;
		sum_res.computed_sum  = hash_n;
		sum_res.last_of_run   = 1'b1;

		push.push_pay = take & is_pay;
		push.push_sum = take & end_of_frame;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hcnt_q  <= '0;
			hdr_q   <= '0;
			rem_q   <= '0;
			hash_q  <= '0;
			sum_q   <= '0;
			scnt_q  <= '0;
		end else if (take) begin
			if (end_of_frame) begin
				phase_q <= PH_HEADER;
				hcnt_q  <= '0;
				hdr_q   <= '0;
				rem_q   <= '0;
				hash_q  <= '0;
				sum_q   <= '0;
				scnt_q  <= '0;
			end else begin
				phase_q <= phase_n;
				hcnt_q  <= hcnt_n;
				hdr_q   <= hdr_n;
				rem_q   <= rem_n;
				hash_q  <= hash_n;
				sum_q   <= sum_n;
				scnt_q  <= scnt_n;
			end
		end
	end

endmodule

FILE: rtl/fdhc_queue.sv
// ----------------------------------------------------------------------------
// fdhc_queue
// Small result queue that takes up to two results in a cycle and gives one.
// ----------------------------------------------------------------------------
module fdhc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  fdhc_pkg::push_t   push,
	input  fdhc_pkg::res_t    pay_res,
	input  fdhc_pkg::res_t    sum_res,
	input  logic              pop,
	output logic              head_valid,
	output fdhc_pkg::res_t    head,
	output fdhc_pkg::qstat_t  stat
);
	import fdhc_pkg::*;

	res_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q, wp_sum;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_pop;

	assign wp_sum     = wp_q + QPTR_W'(push.push_pay);
	assign do_pop     = pop & (cnt_q != '0);
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rp_q];
	assign stat.level = cnt_q;
	assign stat.room  = (cnt_q <= QCNT_W'(QDEPTH - 2));

	always_ff @(posedge clk) begin
		for (int e = 0; e < QDEPTH; e++) begin
			if (push.push_pay && wp_q == QPTR_W'(e)) begin
				mem_q[e] <= pay_res;
			end else if (push.push_sum && wp_sum == QPTR_W'(e)) begin
				mem_q[e] <= sum_res;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + QPTR_W'(push.push_pay) + QPTR_W'(push.push_sum);
			rp_q  <= rp_q + QPTR_W'(do_pop);
			cnt_q <= cnt_q + QCNT_W'(push.push_pay) + QCNT_W'(push.push_sum)
				- QCNT_W'(do_pop);
		end
	end

endmodule

FILE: rtl/frame_deframer_hash_check_top.sv
// ----------------------------------------------------------------------------
// frame_deframer_hash_check_top
// Length-prefixed frame deframer with a multiplicative hash check.
// ----------------------------------------------------------------------------
// A result is registered in the queue and can be taken in the cycle after the
// word that causes it. Throughput: one word per cycle, set by the state update
// and the four-entry result queue; a final word that also carries payload queues
// two results, and the queue accepts words while at least two entries are free.
// Reset: arst_n clears the frame state and empties the result queue.
// ----------------------------------------------------------------------------
module frame_deframer_hash_check_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_frame,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  item_kind,
	output logic [7:0]  payload_byte,
	output logic [1:0]  frame_status,
	output logic [15:0] version_field,
	output logic [15:0] command_field,
	output logic [63:0] request_ident,
	output logic [31:0] user_length,
	output logic [31:0] body_length,
	output logic [31:0] stored_sum,
	output logic [31:0] computed_sum,
	output logic        last_of_run
);
	import fdhc_pkg::*;

	push_t  push;
	res_t   pay_res, sum_res, head;
	qstat_t stat;
	logic   take;

	assign in_ready = stat.room;
	assign take     = in_valid & in_ready;

	fdhc_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.data_byte    (data_byte),
		.end_of_frame (end_of_frame),
		.push         (push),
		.pay_res      (pay_res),
		.sum_res      (sum_res)
	);

	fdhc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pay_res    (pay_res),
		.sum_res    (sum_res),
		.pop        (out_ready),
		.head_valid (out_valid),
		.head       (head),
		.stat       (stat)
	);

	assign item_kind     = head.item_kind;
	assign payload_byte  = head.payload_byte;
	assign frame_status  = head.frame_status;
	assign version_field = head.version_field;
	assign command_field = head.command_field;
	assign request_ident = head.request_ident;
	assign user_length   = head.user_length;
	assign body_length   = head.body_length;
	assign stored_sum    = head.stored_sum;
	assign computed_sum  = head.computed_sum;
	assign last_of_run   = head.last_of_run;

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.level <= QCNT_W'(QDEPTH))
		else $error("result queue level exceeds its depth");

	a_eof_gives_summary: assert property (@(posedge clk) disable iff (!arst_n)
		take && end_of_frame |=> out_valid)
		else $error("no result queued after a final word");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind != KIND_SUMMARY |->
		frame_status == ST_OK && computed_sum == 32'd0 && stored_sum == 32'd0)
		else $error("payload result carries summary fields");

	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind == KIND_SUMMARY |-> last_of_run && payload_byte == 8'd0)
		else $error("summary result is not marked last");

endmodule

FILE: dv/frame_result_checker.sv
// ----------------------------------------------------------------------------
// frame_result_checker
// Watches both channels of the frame deframer, works out the payload words
// and frame summaries that each accepted input word must cause, and compares
// every accepted result with the oldest one still awaited.
// ----------------------------------------------------------------------------
module frame_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_frame,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  item_kind,
	input  logic [7:0]  payload_byte,
	input  logic [1:0]  frame_status,
	input  logic [15:0] version_field,
	input  logic [15:0] command_field,
	input  logic [63:0] request_ident,
	input  logic [31:0] user_length,
	input  logic [31:0] body_length,
	input  logic [31:0] stored_sum,
	input  logic [31:0] computed_sum,
	input  logic        last_of_run,
	output int unsigned fail_count,
	output int unsigned results_awaited,
	output int unsigned results_checked,
	output int unsigned summaries_checked
);

	timeunit 1ns;
	timeprecision 1ps;

	import fdhc_pkg::*;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_USER,
		PH_BODY,
		PH_SUM,
		PH_DONE
	} frame_phase_e;

	localparam logic [31:0] HASH_MULT = 32'd131;

	frame_phase_e phase_q;
	logic [4:0]   hdr_seen;
	logic [15:0]  version_q;
	logic [15:0]  command_q;
	logic [63:0]  request_q;
	logic [31:0]  user_len_q;
	logic [31:0]  body_len_q;
	logic [31:0]  remaining_q;
	logic [31:0]  hash_q;
	logic [31:0]  stored_q;
	logic [2:0]   sum_seen;
	res_t         awaited_results[$];

	initial begin
		fail_count = 0;
		results_awaited = 0;
		results_checked = 0;
		summaries_checked = 0;
	end

	task automatic clear_frame();
		phase_q = PH_HEADER;
		hdr_seen = '0;
		version_q = '0;
		command_q = '0;
		request_q = '0;
		user_len_q = '0;
		body_len_q = '0;
		remaining_q = '0;
		hash_q = '0;
		stored_q = '0;
		sum_seen = '0;
	endtask

	task automatic enter_after_user();
		if (body_len_q != 0) begin
			phase_q = PH_BODY;
			remaining_q = body_len_q;
		end else begin
			phase_q = PH_SUM;
		end
	endtask

	task automatic deframe_word(input logic [7:0] b, input logic eof);
		res_t       r;
		logic [1:0] verdict;
		case (phase_q)
			PH_HEADER: begin
				if (hdr_seen < 2)
					version_q[8*hdr_seen +: 8] = b;
				else if (hdr_seen < 4)
					command_q[8*(hdr_seen-2) +: 8] = b;
				else if (hdr_seen < 12)
					request_q[8*(hdr_seen-4) +: 8] = b;
				else if (hdr_seen < 16)
					user_len_q[8*(hdr_seen-12) +: 8] = b;
				else
					body_len_q[8*(hdr_seen-16) +: 8] = b;
				hdr_seen = hdr_seen + 5'd1;
				if (hdr_seen == HDR_LEN) begin
					if (user_len_q != 0) begin
						phase_q = PH_USER;
						remaining_q = user_len_q;
					end else begin
						enter_after_user();
					end
				end
			end
			PH_USER, PH_BODY: begin
				r = '0;
				r.item_kind = (phase_q == PH_USER) ? KIND_USER : KIND_BODY;
				r.payload_byte = b;
				r.last_of_run = !eof;
				awaited_results.push_back(r);
				hash_q = hash_q * HASH_MULT + b;
				remaining_q = remaining_q - 32'd1;
				if (remaining_q == 0) begin
					if (phase_q == PH_USER)
						enter_after_user();
					else
						phase_q = PH_SUM;
				end
			end
			PH_SUM: begin
				stored_q[8*sum_seen[1:0] +: 8] = b;
				sum_seen = sum_seen + 3'd1;
				if (sum_seen >= SUM_LEN)
					phase_q = PH_DONE;
			end
			default: begin
			end
		endcase

		if (eof) begin
			if (phase_q == PH_HEADER)
				verdict = ST_SHORT;
			else if (phase_q == PH_DONE)
				verdict = (stored_q == hash_q) ? ST_OK : ST_MISMATCH;
			else
				verdict = ST_TRUNC;
			r = '0;
			r.item_kind = KIND_SUMMARY;
			r.frame_status = verdict;
			r.version_field = version_q;
			r.command_field = command_q;
			r.request_ident = request_q;
			r.user_length = user_len_q;
			r.body_length = body_len_q;
			r.stored_sum = stored_q;
			r.computed_sum = hash_q;
			r.last_of_run = 1'b1;
			awaited_results.push_back(r);
			clear_frame();
		end
	endtask

	task automatic check_field(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		res_t want;
		if (!arst_n) begin
			clear_frame();
			awaited_results.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: result with nothing awaited: expected none, actual kind %0d",
						$time, item_kind);
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					check_field("item_kind", want.item_kind, item_kind);
					check_field("payload_byte", want.payload_byte, payload_byte);
					check_field("frame_status", want.frame_status, frame_status);
					check_field("version_field", want.version_field, version_field);
					check_field("command_field", want.command_field, command_field);
					check_field("request_ident", want.request_ident, request_ident);
					check_field("user_length", want.user_length, user_length);
					check_field("body_length", want.body_length, body_length);
					check_field("stored_sum", want.stored_sum, stored_sum);
					check_field("computed_sum", want.computed_sum, computed_sum);
					check_field("last_of_run", want.last_of_run, last_of_run);
					results_checked++;
					if (want.item_kind == KIND_SUMMARY)
						summaries_checked++;
				end
			end
			if (in_valid && in_ready)
				deframe_word(data_byte, end_of_frame);
		end
		results_awaited = awaited_results.size();
	end

endmodule

FILE: dv/frame_deframer_hash_check_top_test.sv
// ----------------------------------------------------------------------------
// frame_deframer_hash_check_top_test
// Feeds the frame deframer with directed and random frames, well formed and
// broken, under shifting sender and receiver stalls, and takes the verdict
// from the result checker that sits beside it.
// ----------------------------------------------------------------------------
module frame_deframer_hash_check_top_test;

	timeunit 1ns;
	timeprecision 1ps;

	import fdhc_pkg::*;

	localparam int unsigned CYCLE_LIMIT    = 200000;
	localparam int unsigned RANDOM_WORDS   = 180;
	localparam int unsigned DRAIN_CYCLES   = 16;
	localparam logic [31:0] HASH_MULT      = 32'd131;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        end_of_frame;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  item_kind;
	logic [7:0]  payload_byte;
	logic [1:0]  frame_status;
	logic [15:0] version_field;
	logic [15:0] command_field;
	logic [63:0] request_ident;
	logic [31:0] user_length;
	logic [31:0] body_length;
	logic [31:0] stored_sum;
	logic [31:0] computed_sum;
	logic        last_of_run;

	int unsigned fail_count;
	int unsigned results_awaited;
	int unsigned results_checked;
	int unsigned summaries_checked;

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned frames_sent;
	int unsigned words_sent;
	int unsigned cycle_count;

	frame_deframer_hash_check_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.end_of_frame (end_of_frame),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.item_kind    (item_kind),
		.payload_byte (payload_byte),
		.frame_status (frame_status),
		.version_field(version_field),
		.command_field(command_field),
		.request_ident(request_ident),
		.user_length  (user_length),
		.body_length  (body_length),
		.stored_sum   (stored_sum),
		.computed_sum (computed_sum),
		.last_of_run  (last_of_run)
	);

	frame_result_checker u_result_checker (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles without completing", cycle_count);
			$display("frame_deframer_hash_check_top_test failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_word(input logic [7:0] b, input logic eof);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_frame <= eof;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (results_awaited != 0)
			@(negedge clk);
	endtask

	task automatic send_frame(input logic [15:0] ver, input logic [15:0] cmd,
			input logic [63:0] req, input logic [31:0] ulen, input logic [31:0] blen,
			input bit corrupt, input int unsigned trail, input longint cut);
		logic [159:0] hdr;
		logic [31:0]  hash;
		logic [31:0]  sum;
		logic [7:0]   b;
		longint       pay_end;
		longint       total;
		longint       i;
		hdr = {blen, ulen, req, cmd, ver};
		pay_end = HDR_LEN + longint'(ulen) + longint'(blen);
		total = pay_end + SUM_LEN + trail;
		if (cut > 0 && cut < total)
			total = cut;
		hash = '0;
		sum = '0;
		for (i = 0; i < total; i++) begin
			if (i < HDR_LEN) begin
				b = hdr[8*i +: 8];
			end else if (i < pay_end) begin
				b = 8'($urandom);
				hash = hash * HASH_MULT + b;
			end else if (i < pay_end + SUM_LEN) begin
				if (i == pay_end)
					sum = corrupt ? hash ^ (32'd1 << $urandom_range(31)) : hash;
				b = sum[8*(i-pay_end) +: 8];
			end else begin
				b = 8'($urandom);
			end
			send_word(b, i == total - 1);
		end
		frames_sent++;
	endtask

	task automatic send_random_frame();
		logic [15:0]  ver;
		logic [15:0]  cmd;
		logic [63:0]  req;
		logic [31:0]  ulen;
		logic [31:0]  blen;
		int unsigned  pick;
		ver = 16'($urandom);
		cmd = 16'($urandom);
		req = {$urandom, $urandom};
		ulen = $urandom_range(6);
		blen = $urandom_range(8);
		pick = $urandom_range(99);
		if (pick < 60) begin
			send_frame(ver, cmd, req, ulen, blen, $urandom_range(3) == 0,
				($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0, 0);
		end else if (pick < 70) begin
			send_frame(ver, cmd, req, ulen, blen, 1'b0, 0, $urandom_range(1, 19));
		end else if (pick < 90) begin
			send_frame(ver, cmd, req, ulen, blen, 1'b0, 0,
				$urandom_range(HDR_LEN, HDR_LEN + ulen + blen + SUM_LEN - 1));
		end else begin
			ulen = $urandom_range(1) ? $urandom : 32'd0;
			blen = $urandom;
			send_frame(ver, cmd, req, ulen, blen, 1'b0, 0, $urandom_range(20, 30));
		end
	endtask

	initial begin
		int unsigned phase_start;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		end_of_frame = 1'b0;
		out_ready = 1'b0;
		cycle_count = 0;
		frames_sent = 0;
		words_sent = 0;
		send_idle_pct = 29;
		recv_idle_pct = 71;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_frame(16'h0000, 16'h0000, 64'h0, 32'd0, 32'd0, 1'b0, 0, 1);
		send_frame(16'hFFFF, 16'hFFFF, '1, '1, '1, 1'b0, 0, 19);
		send_frame(16'h1234, 16'hABCD, 64'h0123456789ABCDEF, 32'd0, 32'd0, 1'b0, 0, 20);
		send_frame(16'hFFFF, 16'hFFFF, '1, 32'd0, 32'd0, 1'b0, 0, 0);
		send_frame(16'h0000, 16'h0000, 64'h0, 32'd3, 32'd2, 1'b0, 0, 0);
		send_frame(16'h0001, 16'h8000, 64'h8000000000000001, 32'd2, 32'd3, 1'b1, 0, 0);
		send_frame(16'h00FF, 16'hFF00, 64'hFFFFFFFF00000000, 32'd1, 32'd0, 1'b0, 3, 0);
		send_frame(16'h5A5A, 16'hA5A5, 64'h00000000FFFFFFFF, 32'd0, 32'd4, 1'b0, 0, 0);
		send_frame(16'h7FFF, 16'h0001, 64'h5555AAAA5555AAAA, 32'd4, 32'd4, 1'b0, 0, 22);
		send_frame(16'h8000, 16'h7FFF, 64'hAAAA5555AAAA5555, 32'd2, 32'd4, 1'b0, 0, 25);
		send_frame(16'h0F0F, 16'hF0F0, 64'h1, 32'd1, 32'd1, 1'b0, 0, 24);
		send_frame(16'hC3C3, 16'h3C3C, 64'h2, '1, '1, 1'b0, 0, 23);
		wait_for_results();

		for (int mix = 0; mix < 3; mix++) begin
			send_idle_pct = (mix == 0) ? 29 : (mix == 1) ? 71 : 0;
			recv_idle_pct = (mix == 0) ? 71 : (mix == 1) ? 29 : 0;
			phase_start = words_sent;
			while (words_sent - phase_start < RANDOM_WORDS / 3)
				send_random_frame();
			wait_for_results();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Sent %0d frames in %0d words: short, truncated, trailing, corrupted and clean.",
			frames_sent, words_sent);
		$display("Checked %0d results, %0d of them frame summaries, under three stall mixes.",
			results_checked, summaries_checked);
		if (fail_count == 0 && results_awaited == 0) begin
			$display("frame_deframer_hash_check_top_test passed");
		end else begin
			$display("%0d failures, %0d results never arrived", fail_count, results_awaited);
			$display("frame_deframer_hash_check_top_test failed");
		end
		$finish;
	end

endmodule
